// ===== rtl/pshs_pkg.sv =====
// Shared types, constants and the sine table for the point-seek heading and speed block.
// No dependencies; every other file in rtl/ refers to it by scoped names.
`default_nettype none

package pshs_pkg;

    localparam int SPEED_W    = 7;
    localparam int PARK_W     = 11;
    localparam int DWELL_W    = 16;
    localparam int TIME_W     = 32;
    localparam int HEAD_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DEG_W      = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int DEF_COORD_BITS = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PARK_DIST  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PARK_DWELL = 2'd3;

    localparam logic [SPEED_W-1:0] RST_MIN_SPEED  = 7'd20;
    localparam logic [SPEED_W-1:0] RST_MAX_SPEED  = 7'd40;
    localparam logic [PARK_W-1:0]  RST_PARK_DIST  = 11'd40;
    localparam logic [DWELL_W-1:0] RST_PARK_DWELL = 16'd200;

    localparam logic [HEAD_W-1:0] HEAD_NORTH = 9'd0;
    localparam logic [HEAD_W-1:0] HEAD_EAST  = 9'd90;
    localparam logic [HEAD_W-1:0] HEAD_SOUTH = 9'd180;
    localparam logic [HEAD_W-1:0] HEAD_WEST  = 9'd270;
    localparam logic [HEAD_W-1:0] HEAD_STOP  = 9'd360;
    localparam logic [HEAD_W-1:0] HEAD_FULL  = 9'd360;

    localparam logic [SPEED_W-1:0] SLOW_SPEED = 7'd5;
    localparam logic [7:0]         SPEED_SPAN = 8'd200;
    // 2^16 / 25 rounded up; exact for quotients of values below 3200.
    localparam logic [11:0]        RECIP_25   = 12'd2622;
    localparam logic [DEG_W-1:0]   DEG_END    = 8'd180;

    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint PI_Q30  = 64'sd3373259426;

    // Divisors (2n)(2n+1) of the Taylor terms, n = 1..12.
    localparam longint TAYLOR_DIV [1:12] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110,
                                            64'sd156, 64'sd210, 64'sd272, 64'sd342,
                                            64'sd420, 64'sd506, 64'sd600};

    typedef enum logic [1:0] {
        KIND_NORMAL,
        KIND_X_BLOCKED,
        KIND_Y_BLOCKED,
        KIND_BOTH
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_DWELL,
        ST_ANGLE,
        ST_SPD_MUL,
        ST_SPD_DIV,
        ST_SPD_ADD,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic [SPEED_W-1:0] min_speed;
        logic [SPEED_W-1:0] max_speed;
        logic [PARK_W-1:0]  park_distance;
        logic [DWELL_W-1:0] park_dwell_ms;
    } t_cfg;

    typedef logic [30:0] t_sin_tab [0:90];

    // Q30 sine of whole degrees 0..90, from a 13-term Taylor series in 64-bit integers.
    function automatic t_sin_tab build_sin_tab();
        t_sin_tab tab;
        longint   x;
        longint   term;
        longint   sum;
        for (int k = 0; k <= 90; k++) begin
            x = (longint'(k) * PI_Q30 + 64'sd90) / 64'sd180;
            term = x;
            sum = x;
            for (int n = 1; n <= 12; n++) begin
                term = term * x / Q30_ONE;
                term = term * x / Q30_ONE;
                term = term / TAYLOR_DIV[n];
                term = -term;
                sum = sum + term;
            end
            tab[k] = sum[30:0];
        end
        tab[90] = 31'h4000_0000;
        return tab;
    endfunction

    localparam t_sin_tab SIN_TAB = build_sin_tab();

    function automatic logic signed [31:0] sin_q30(input logic [DEG_W-1:0] d);
        logic [DEG_W-1:0] idx;
        idx = (d <= 8'd90) ? d : (8'd180 - d);
        return $signed({1'b0, SIN_TAB[idx[6:0]]});
    endfunction

    function automatic logic signed [31:0] cos_q30(input logic [DEG_W-1:0] d);
        logic [DEG_W-1:0] idx;
        idx = (d <= 8'd90) ? (8'd90 - d) : (d - 8'd90);
        if (d <= 8'd90) begin
            return $signed({1'b0, SIN_TAB[idx[6:0]]});
        end else begin
            return -$signed({1'b0, SIN_TAB[idx[6:0]]});
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pshs_queue.sv =====
// Two-entry first-in first-out queue between the front and back parts.
// Generic payload width; uses pshs_pkg for the depth.
`default_nettype none

module pshs_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push_valid,
    output logic                  o_push_ready,
    input  wire logic [WIDTH-1:0] i_push_data,
    output logic                  o_pop_valid,
    input  wire logic             i_pop_ready,
    output logic [WIDTH-1:0]      o_pop_data
);

    localparam int PTR_W = $clog2(pshs_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(pshs_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [pshs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_cnt != CNT_W'(pshs_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rp];
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pshs_front.sv =====
// Front part: accepts input beats, forms the offsets and classifies the blocked axes.
// Uses pshs_pkg for the item kind and time width.
`default_nettype none

module pshs_front #(
    parameter int COORD_BITS = pshs_pkg::DEF_COORD_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic signed [COORD_BITS-1:0]  i_cur_x,
    input  wire logic signed [COORD_BITS-1:0]  i_cur_y,
    input  wire logic signed [COORD_BITS-1:0]  i_goal_x,
    input  wire logic signed [COORD_BITS-1:0]  i_goal_y,
    input  wire logic                          i_x_blocked,
    input  wire logic                          i_y_blocked,
    input  wire logic [pshs_pkg::TIME_W-1:0]   i_now_ms,
    output logic                               o_item_valid,
    input  wire logic                          i_item_ready,
    output logic signed [COORD_BITS:0]         o_dx,
    output logic signed [COORD_BITS:0]         o_dy,
    output pshs_pkg::t_kind                    o_kind,
    output logic [pshs_pkg::TIME_W-1:0]        o_now
);

    logic                         r_v;
    logic signed [COORD_BITS:0]   r_dx;
    logic signed [COORD_BITS:0]   r_dy;
    pshs_pkg::t_kind              r_kind;
    logic [pshs_pkg::TIME_W-1:0]  r_now;
    pshs_pkg::t_kind              kind;
    logic                         take;

    assign o_in_ready   = !r_v || i_item_ready;
    assign take         = i_in_valid && o_in_ready;
    assign o_item_valid = r_v;
    assign o_dx   = r_dx;
    assign o_dy   = r_dy;
    assign o_kind = r_kind;
    assign o_now  = r_now;

    always_comb begin
        case ({i_x_blocked, i_y_blocked})
            2'b10:   kind = pshs_pkg::KIND_X_BLOCKED;
            2'b01:   kind = pshs_pkg::KIND_Y_BLOCKED;
            2'b11:   kind = pshs_pkg::KIND_BOTH;
            default: kind = pshs_pkg::KIND_NORMAL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (take) begin
            r_v <= 1'b1;
        end else if (i_item_ready) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_dx   <= $signed({i_goal_x[COORD_BITS-1], i_goal_x})
                    - $signed({i_cur_x[COORD_BITS-1], i_cur_x});
            r_dy   <= $signed({i_goal_y[COORD_BITS-1], i_goal_y})
                    - $signed({i_cur_y[COORD_BITS-1], i_cur_y});
            r_kind <= kind;
            r_now  <= i_now_ms;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pshs_back.sv =====
// Back part: square root, bearing search, parking dwell, speed and the result register.
// Uses pshs_pkg for states, configuration struct, constants and the sine table.
`default_nettype none

module pshs_back #(
    parameter int COORD_BITS = pshs_pkg::DEF_COORD_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire pshs_pkg::t_cfg                i_cfg,
    input  wire logic                          i_item_valid,
    output logic                               o_item_ready,
    input  wire logic signed [COORD_BITS:0]    i_dx,
    input  wire logic signed [COORD_BITS:0]    i_dy,
    input  wire pshs_pkg::t_kind               i_kind,
    input  wire logic [pshs_pkg::TIME_W-1:0]   i_now,
    output logic                               o_res_valid,
    input  wire logic                          i_res_ready,
    output logic [pshs_pkg::HEAD_W-1:0]        o_heading,
    output logic [pshs_pkg::SPEED_W-1:0]       o_speed_cmd,
    output logic                               o_is_parked
);

    localparam int DW    = COORD_BITS + 1;
    localparam int SQW   = 2 * COORD_BITS;
    localparam int RW    = 2 * COORD_BITS + 2;
    localparam int PW    = COORD_BITS + 34;
    localparam int CMP_W = (DW > pshs_pkg::PARK_W) ? DW : pshs_pkg::PARK_W;
    localparam int HW    = pshs_pkg::HEAD_W;
    localparam int SW    = pshs_pkg::SPEED_W;
    localparam int TW    = pshs_pkg::TIME_W;
    localparam int GW    = pshs_pkg::DEG_W;

    pshs_pkg::t_state r_state, n_state;

    logic signed [DW-1:0] r_dx, n_dx, r_dy, n_dy;
    logic [TW-1:0]        r_now, n_now;
    logic                 r_parked, n_parked, r_armed, n_armed;
    logic [TW-1:0]        r_start, n_start;
    logic [HW-1:0]        r_last_head, n_last_head;
    logic [SW-1:0]        r_last_speed, n_last_speed;
    logic [SQW-1:0]       r_sqx, n_sqx, r_sqy, n_sqy;
    logic [RW-1:0]        r_v, n_v, r_r, n_r, r_bit, n_bit;
    logic [HW-1:0]        r_head, n_head;
    logic [DW-1:0]        r_abs, n_abs;
    logic [GW-1:0]        r_deg, n_deg, r_pdeg, n_pdeg, r_best, n_best;
    logic                 r_pv, n_pv;
    logic signed [PW-1:0] r_pc, n_pc, r_ps, n_ps;
    logic                 r_big, n_big, r_lohi, n_lohi;
    logic [14:0]          r_prod, n_prod;
    logic [SW-1:0]        r_q, n_q, r_spd, n_spd;
    logic                 r_ov, n_ov;
    logic [HW-1:0]        r_o_head, n_o_head;
    logic [SW-1:0]        r_o_speed, n_o_speed;
    logic                 r_o_parked, n_o_parked;

    logic                    silent;
    logic signed [2*DW-1:0]  sq_x_full, sq_y_full;
    logic [RW-1:0]           trial;
    logic [DW-1:0]           root;
    logic [DW-1:0]           abs_dx, abs_dy, abs_idx, abs_idy;
    logic signed [PW-1:0]    cos_prod, sin_prod;
    logic [PW:0]             diff;
    logic [SW-1:0]           span;
    logic [23:0]             q_full;
    logic [TW-1:0]           elapsed;
    logic                    near;

    assign o_res_valid = r_ov;
    assign o_heading   = r_o_head;
    assign o_speed_cmd = r_o_speed;
    assign o_is_parked = r_o_parked;

    assign silent = r_parked && ((r_last_speed < pshs_pkg::SLOW_SPEED)
                              || (r_last_head == pshs_pkg::HEAD_STOP));
    assign sq_x_full = (2*DW)'(r_dx) * (2*DW)'(r_dx);
    assign sq_y_full = (2*DW)'(r_dy) * (2*DW)'(r_dy);
    assign trial     = r_r + r_bit;
    assign root      = r_r[DW-1:0];
    assign abs_dx    = r_dx[DW-1] ? DW'(-r_dx) : DW'(r_dx);
    assign abs_dy    = r_dy[DW-1] ? DW'(-r_dy) : DW'(r_dy);
    assign abs_idx   = i_dx[DW-1] ? DW'(-i_dx) : DW'(i_dx);
    assign abs_idy   = i_dy[DW-1] ? DW'(-i_dy) : DW'(i_dy);
    assign cos_prod  = PW'(pshs_pkg::cos_q30(r_deg)) * PW'($signed({1'b0, abs_dx}));
    assign sin_prod  = PW'(pshs_pkg::sin_q30(r_deg)) * PW'(r_dy);
    assign diff      = {r_pc[PW-1], r_pc} - {r_ps[PW-1], r_ps};
    assign span      = i_cfg.max_speed - i_cfg.min_speed;
    assign q_full    = 24'(r_prod[14:3]) * 24'(pshs_pkg::RECIP_25);
    assign elapsed   = r_now - r_start;
    assign near      = CMP_W'(root) < CMP_W'(i_cfg.park_distance);

    always_comb begin
        n_state = r_state;
        n_dx = r_dx;  n_dy = r_dy;  n_now = r_now;
        n_parked = r_parked;  n_armed = r_armed;  n_start = r_start;
        n_last_head = r_last_head;  n_last_speed = r_last_speed;
        n_sqx = r_sqx;  n_sqy = r_sqy;
        n_v = r_v;  n_r = r_r;  n_bit = r_bit;
        n_head = r_head;  n_abs = r_abs;
        n_deg = r_deg;  n_pdeg = r_pdeg;  n_best = r_best;  n_pv = r_pv;
        n_pc = r_pc;  n_ps = r_ps;
        n_big = r_big;  n_lohi = r_lohi;  n_prod = r_prod;  n_q = r_q;  n_spd = r_spd;
        n_ov = r_ov && !i_res_ready;
        n_o_head = r_o_head;  n_o_speed = r_o_speed;  n_o_parked = r_o_parked;
        o_item_ready = 1'b0;

        case (r_state)
            pshs_pkg::ST_IDLE: begin
                o_item_ready = 1'b1;
                if (i_item_valid && !silent) begin
                    n_dx  = i_dx;
                    n_dy  = i_dy;
                    n_now = i_now;
                    case (i_kind)
                        pshs_pkg::KIND_NORMAL: begin
                            n_state = pshs_pkg::ST_SQUARE;
                        end
                        pshs_pkg::KIND_X_BLOCKED: begin
                            n_parked = 1'b0;
                            n_head = (!i_dy[DW-1] && (i_dy != '0)) ? pshs_pkg::HEAD_NORTH
                                                                    : pshs_pkg::HEAD_SOUTH;
                            n_abs = abs_idy;
                            n_state = pshs_pkg::ST_SPD_MUL;
                        end
                        pshs_pkg::KIND_Y_BLOCKED: begin
                            n_parked = 1'b0;
                            n_head = (!i_dx[DW-1] && (i_dx != '0)) ? pshs_pkg::HEAD_EAST
                                                                    : pshs_pkg::HEAD_WEST;
                            n_abs = abs_idx;
                            n_state = pshs_pkg::ST_SPD_MUL;
                        end
                        default: begin
                            n_parked = 1'b0;
                            n_head = pshs_pkg::HEAD_STOP;
                            n_abs = '0;
                            n_state = pshs_pkg::ST_SPD_MUL;
                        end
                    endcase
                end
            end
            pshs_pkg::ST_SQUARE: begin
                n_sqx = sq_x_full[SQW-1:0];
                n_sqy = sq_y_full[SQW-1:0];
                n_state = pshs_pkg::ST_SUM;
            end
            pshs_pkg::ST_SUM: begin
                n_v = RW'(r_sqx) + RW'(r_sqy);
                n_r = '0;
                n_bit = '0;
                n_bit[RW-2] = 1'b1;
                n_state = pshs_pkg::ST_ROOT;
            end
            pshs_pkg::ST_ROOT: begin
                if (r_bit == '0) begin
                    n_state = pshs_pkg::ST_DWELL;
                end else begin
                    if (r_v >= trial) begin
                        n_v = r_v - trial;
                        n_r = (r_r >> 1) + r_bit;
                    end else begin
                        n_r = r_r >> 1;
                    end
                    n_bit = r_bit >> 2;
                end
            end
            pshs_pkg::ST_DWELL: begin
                n_abs = root;
                n_parked = 1'b0;
                if (near) begin
                    if (r_armed) begin
                        n_parked = (elapsed > TW'(i_cfg.park_dwell_ms));
                    end else begin
                        n_armed = 1'b1;
                        n_start = r_now;
                    end
                end else begin
                    n_armed = 1'b0;
                end
                n_deg = '0;
                n_pv = 1'b0;
                n_best = '0;
                if (near && r_armed && (elapsed > TW'(i_cfg.park_dwell_ms))) begin
                    n_head = pshs_pkg::HEAD_STOP;
                    n_state = pshs_pkg::ST_SPD_MUL;
                end else if (r_dx == '0) begin
                    n_head = r_dy[DW-1] ? pshs_pkg::HEAD_SOUTH : pshs_pkg::HEAD_NORTH;
                    n_state = pshs_pkg::ST_SPD_MUL;
                end else begin
                    n_state = pshs_pkg::ST_ANGLE;
                end
            end
            pshs_pkg::ST_ANGLE: begin
                if (r_deg != pshs_pkg::DEG_END) begin
                    n_pc = cos_prod;
                    n_ps = sin_prod;
                    n_pdeg = r_deg;
                    n_pv = 1'b1;
                    n_deg = r_deg + GW'(1);
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv && !diff[PW]) begin
                    n_best = r_pdeg;
                end
                if ((r_deg == pshs_pkg::DEG_END) && !r_pv) begin
                    if (!r_dx[DW-1]) begin
                        n_head = HW'(r_best);
                    end else if (r_best == '0) begin
                        n_head = pshs_pkg::HEAD_NORTH;
                    end else begin
                        n_head = pshs_pkg::HEAD_FULL - HW'(r_best);
                    end
                    n_state = pshs_pkg::ST_SPD_MUL;
                end
            end
            pshs_pkg::ST_SPD_MUL: begin
                n_lohi = (i_cfg.max_speed < i_cfg.min_speed);
                n_big  = (r_abs >= DW'(pshs_pkg::SPEED_SPAN));
                n_prod = 15'(span) * 15'(r_abs[7:0]);
                n_state = pshs_pkg::ST_SPD_DIV;
            end
            pshs_pkg::ST_SPD_DIV: begin
                n_q = q_full[22:16];
                n_state = pshs_pkg::ST_SPD_ADD;
            end
            pshs_pkg::ST_SPD_ADD: begin
                // With the floor above the ceiling, a zero distance leaves the sum at the
                // floor, which then clamps to the ceiling; any other distance falls below
                // the floor and clamps back up to it.
                if (r_lohi) begin
                    n_spd = (r_abs == '0) ? i_cfg.max_speed : i_cfg.min_speed;
                end else if (r_big) begin
                    n_spd = i_cfg.max_speed;
                end else begin
                    n_spd = i_cfg.min_speed + r_q;
                end
                n_state = pshs_pkg::ST_RESULT;
            end
            pshs_pkg::ST_RESULT: begin
                if (!r_ov || i_res_ready) begin
                    n_ov = 1'b1;
                    n_o_head = r_head;
                    n_o_speed = r_spd;
                    n_o_parked = r_parked;
                    n_last_head = r_head;
                    n_last_speed = r_spd;
                    n_state = pshs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pshs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pshs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parked     <= 1'b0;
            r_armed      <= 1'b0;
            r_start      <= '0;
            r_last_head  <= '0;
            r_last_speed <= '0;
            r_ov         <= 1'b0;
        end else begin
            r_parked     <= n_parked;
            r_armed      <= n_armed;
            r_start      <= n_start;
            r_last_head  <= n_last_head;
            r_last_speed <= n_last_speed;
            r_ov         <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx <= n_dx;  r_dy <= n_dy;  r_now <= n_now;
        r_sqx <= n_sqx;  r_sqy <= n_sqy;
        r_v <= n_v;  r_r <= n_r;  r_bit <= n_bit;
        r_head <= n_head;  r_abs <= n_abs;
        r_deg <= n_deg;  r_pdeg <= n_pdeg;  r_best <= n_best;  r_pv <= n_pv;
        r_pc <= n_pc;  r_ps <= n_ps;
        r_big <= n_big;  r_lohi <= n_lohi;  r_prod <= n_prod;  r_q <= n_q;  r_spd <= n_spd;
        r_o_head <= n_o_head;  r_o_speed <= n_o_speed;  r_o_parked <= n_o_parked;
    end

endmodule

`default_nettype wire

// ===== rtl/point_seek_heading_speed_top.sv =====
// Top level of the point-seek heading and speed block: configuration registers and wiring.
// Depends on pshs_pkg, pshs_front, pshs_queue and pshs_back.
`default_nettype none

// The block steers a robot toward a goal point. Each input beat carries the current and
// goal positions, two blocked-axis flags and a millisecond timestamp; each beat yields at
// most one result beat with a heading in whole degrees clockwise from +y (360 means stop),
// a speed command and the parked flag. A front stage takes input beats, forms the offsets
// and classifies them by blocked axes, then passes them through a two-entry queue to the
// back part, which handles one item at a time. On the unblocked path the back part takes
// the item, forms the squared length, runs the integer square root (one result bit per
// cycle), checks the parking dwell, searches the bearing (one degree per cycle over 180
// degrees, then drains the product pipeline), works out the speed in multiply, divide and
// add steps and loads the result register. A parked result or a goal straight along the
// y axis skips the search, a blocked item goes from taking straight to the speed steps,
// and an item that arrives once the block is parked is dropped without a result. The back
// part holds in its result state while an earlier result still waits at the output. Once
// parked, the block stays silent until reset. Configuration writes take effect at once
// and belong only in periods when no beat is in flight.
module point_seek_heading_speed_top #(
    parameter int COORD_BITS = pshs_pkg::DEF_COORD_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [pshs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [pshs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic signed [COORD_BITS-1:0]      i_cur_x,
    input  wire logic signed [COORD_BITS-1:0]      i_cur_y,
    input  wire logic signed [COORD_BITS-1:0]      i_goal_x,
    input  wire logic signed [COORD_BITS-1:0]      i_goal_y,
    input  wire logic                              i_x_blocked,
    input  wire logic                              i_y_blocked,
    input  wire logic [pshs_pkg::TIME_W-1:0]       i_now_ms,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [pshs_pkg::HEAD_W-1:0]            o_heading,
    output logic [pshs_pkg::SPEED_W-1:0]           o_speed_cmd,
    output logic                                   o_is_parked
);

    localparam int DW = COORD_BITS + 1;
    localparam int QW = 2 * DW + 2 + pshs_pkg::TIME_W;

    // Configuration registers, written in place with no handshake.
    pshs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_speed     <= pshs_pkg::RST_MIN_SPEED;
            r_cfg.max_speed     <= pshs_pkg::RST_MAX_SPEED;
            r_cfg.park_distance <= pshs_pkg::RST_PARK_DIST;
            r_cfg.park_dwell_ms <= pshs_pkg::RST_PARK_DWELL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pshs_pkg::CFG_MIN_SPEED: begin
                    r_cfg.min_speed <= i_cfg_data[pshs_pkg::SPEED_W-1:0];
                end
                pshs_pkg::CFG_MAX_SPEED: begin
                    r_cfg.max_speed <= i_cfg_data[pshs_pkg::SPEED_W-1:0];
                end
                pshs_pkg::CFG_PARK_DIST: begin
                    r_cfg.park_distance <= i_cfg_data[pshs_pkg::PARK_W-1:0];
                end
                pshs_pkg::CFG_PARK_DWELL: begin
                    r_cfg.park_dwell_ms <= i_cfg_data[pshs_pkg::DWELL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Front stage to queue.
    logic                          f_valid;
    logic                          f_ready;
    logic signed [DW-1:0]          f_dx;
    logic signed [DW-1:0]          f_dy;
    pshs_pkg::t_kind               f_kind;
    logic [pshs_pkg::TIME_W-1:0]   f_now;

    pshs_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cur_x      (i_cur_x),
        .i_cur_y      (i_cur_y),
        .i_goal_x     (i_goal_x),
        .i_goal_y     (i_goal_y),
        .i_x_blocked  (i_x_blocked),
        .i_y_blocked  (i_y_blocked),
        .i_now_ms     (i_now_ms),
        .o_item_valid (f_valid),
        .i_item_ready (f_ready),
        .o_dx         (f_dx),
        .o_dy         (f_dy),
        .o_kind       (f_kind),
        .o_now        (f_now)
    );

    // The queue lets the front keep taking beats while the back is busy.
    logic          q_valid;
    logic          q_ready;
    logic [QW-1:0] q_data;

    pshs_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  ({f_dx, f_dy, f_kind, f_now}),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_data)
    );

    logic signed [DW-1:0]          b_dx;
    logic signed [DW-1:0]          b_dy;
    pshs_pkg::t_kind               b_kind;
    logic [pshs_pkg::TIME_W-1:0]   b_now;

    assign b_dx   = $signed(q_data[QW-1 -: DW]);
    assign b_dy   = $signed(q_data[QW-DW-1 -: DW]);
    assign b_kind = pshs_pkg::t_kind'(q_data[pshs_pkg::TIME_W+1 -: 2]);
    assign b_now  = q_data[pshs_pkg::TIME_W-1:0];

    pshs_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (q_valid),
        .o_item_ready (q_ready),
        .i_dx         (b_dx),
        .i_dy         (b_dy),
        .i_kind       (b_kind),
        .i_now        (b_now),
        .o_res_valid  (o_out_valid),
        .i_res_ready  (i_out_ready),
        .o_heading    (o_heading),
        .o_speed_cmd  (o_speed_cmd),
        .o_is_parked  (o_is_parked)
    );

    // A parked result always commands a stop.
    a_parked_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_parked |-> o_heading == pshs_pkg::HEAD_STOP)
        else $error("parked result without stop heading");

    // Headings never leave the 0..360 range.
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_heading <= pshs_pkg::HEAD_STOP)
        else $error("heading out of range");

    // A beat leaving the queue is one the front pushed earlier.
    a_queue_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid && !$past(q_valid) |-> $past(f_valid))
        else $error("queue produced a beat that was never pushed");

endmodule

`default_nettype wire

// ===== test/point_seek_heading_speed_top_tb.sv =====
// Self-checking testbench for point_seek_heading_speed_top: directed and random beats,
// a built-in heading and speed predictor, random idling and a long output stall.
// Depends on pshs_pkg and the RTL under rtl/.
`default_nettype none

module point_seek_heading_speed_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = pshs_pkg::DEF_COORD_BITS;

    typedef struct {
        logic signed [CB-1:0]        cx, cy, gx, gy;
        bit                          xb, yb;
        logic [pshs_pkg::TIME_W-1:0] now;
    } t_pose;

    typedef struct {
        logic [pshs_pkg::HEAD_W-1:0]  head;
        logic [pshs_pkg::SPEED_W-1:0] spd;
        bit                           parked;
    } t_steer;

    // Shadow of the block: registers plus the parking and last-command state.
    typedef struct {
        int unsigned                 min_spd, max_spd, park_dist, dwell;
        bit                          parked, armed;
        logic [pshs_pkg::TIME_W-1:0] start;
        int unsigned                 lhead, lspd;
    } t_nav;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [pshs_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [pshs_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [CB-1:0] i_cur_x = '0, i_cur_y = '0, i_goal_x = '0, i_goal_y = '0;
    logic i_x_blocked = 1'b0, i_y_blocked = 1'b0;
    logic [pshs_pkg::TIME_W-1:0] i_now_ms = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [pshs_pkg::HEAD_W-1:0] o_heading;
    logic [pshs_pkg::SPEED_W-1:0] o_speed_cmd;
    logic o_is_parked;

    point_seek_heading_speed_top #(.COORD_BITS(CB)) dut (.*);

    t_pose  pose_q[$];
    t_steer steer_q[$];
    t_nav   nav;
    longint sin_q[0:90];
    int     fails = 0;
    bit     calm = 1'b0;
    bit     in_taken = 1'b0;
    int     hold_left = 0;
    longint cycles = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Q30 sine of whole degrees by a 13-term Taylor series, entry 90 pinned to one.
    function automatic void make_sines();
        longint x, term, sum;
        for (int k = 0; k <= 90; k++) begin
            x = (longint'(k) * 64'sd3373259426 + 64'sd90) / 64'sd180;
            term = x;
            sum = x;
            for (int n = 1; n <= 12; n++) begin
                term = term * x / 64'sd1073741824;
                term = term * x / 64'sd1073741824;
                term = term / longint'((2 * n) * (2 * n + 1));
                term = -term;
                sum += term;
            end
            sin_q[k] = sum;
        end
        sin_q[90] = 64'sd1073741824;
    endfunction

    // Whole-degree floor of the bearing for a positive x offset.
    function automatic int deg_floor(longint dx, longint dy);
        longint s, c;
        int best;
        best = 0;
        for (int d = 0; d < 180; d++) begin
            s = (d <= 90) ? sin_q[d] : sin_q[180 - d];
            c = (d <= 90) ? sin_q[90 - d] : -sin_q[d - 90];
            if (c * dx - s * dy >= 0) best = d;
        end
        return best;
    endfunction

    function automatic longint root_floor(longint v);
        longint r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            if ((r + (64'sd1 <<< b)) * (r + (64'sd1 <<< b)) <= v) r += (64'sd1 <<< b);
        end
        return r;
    endfunction

    // Returns 1 when the beat yields a command; updates the shadow state.
    function automatic bit steer(inout t_nav s, input t_pose p, output t_steer c);
        longint dx, dy, reach, lo, hi, sp;
        int head, f;
        c = '{default: 0};
        if (s.parked && (s.lspd < pshs_pkg::SLOW_SPEED || s.lhead == pshs_pkg::HEAD_STOP))
            return 1'b0;
        dx = longint'(p.gx) - longint'(p.cx);
        dy = longint'(p.gy) - longint'(p.cy);
        s.parked = 1'b0;
        if (p.xb && !p.yb) begin
            head = int'((p.gy > p.cy) ? pshs_pkg::HEAD_NORTH : pshs_pkg::HEAD_SOUTH);
            reach = dy;
        end else if (p.yb && !p.xb) begin
            head = int'((p.gx > p.cx) ? pshs_pkg::HEAD_EAST : pshs_pkg::HEAD_WEST);
            reach = dx;
        end else if (p.xb && p.yb) begin
            head = int'(pshs_pkg::HEAD_STOP);
            reach = 0;
        end else begin
            reach = root_floor(dx * dx + dy * dy);
            if (reach < s.park_dist) begin
                if (s.armed) begin
                    if ((p.now - s.start) > s.dwell) s.parked = 1'b1;
                end else begin
                    s.armed = 1'b1;
                    s.start = p.now;
                end
            end else begin
                s.armed = 1'b0;
            end
            if (s.parked) head = int'(pshs_pkg::HEAD_STOP);
            else if (dx == 0)
                head = int'((dy >= 0) ? pshs_pkg::HEAD_NORTH : pshs_pkg::HEAD_SOUTH);
            else if (dx > 0) head = deg_floor(dx, dy);
            else begin
                f = deg_floor(-dx, dy);
                head = (f == 0) ? int'(pshs_pkg::HEAD_NORTH) : int'(pshs_pkg::HEAD_FULL) - f;
            end
        end
        lo = s.min_spd;
        hi = s.max_spd;
        if (reach < 0) reach = -reach;
        sp = (200 * lo + (hi - lo) * reach) / 200;
        if (sp < lo) sp = lo;
        else if (sp > hi) sp = hi;
        s.lhead = head;
        s.lspd = int'(sp & 64'sh7F);
        c.head = head[pshs_pkg::HEAD_W-1:0];
        c.spd = sp[pshs_pkg::SPEED_W-1:0];
        c.parked = s.parked;
        return 1'b1;
    endfunction

    // Queues one beat with its expected command. Outside the final parking test a beat
    // that would park the block is moved in time so that the dwell has not yet run out.
    task automatic queue_pose(input t_pose p, input bit let_park);
        t_nav   t;
        t_steer c;
        bit     has;
        t = nav;
        has = steer(t, p, c);
        if (has && c.parked && !let_park) begin
            p.now = nav.start;
            t = nav;
            has = steer(t, p, c);
        end
        nav = t;
        pose_q.push_back(p);
        if (has) steer_q.push_back(c);
    endtask

    function automatic t_pose make_pose(int cx, int cy, int gx, int gy, bit xb, bit yb,
                                        logic [pshs_pkg::TIME_W-1:0] now);
        t_pose p;
        p.cx = cx[CB-1:0]; p.cy = cy[CB-1:0]; p.gx = gx[CB-1:0]; p.gy = gy[CB-1:0];
        p.xb = xb; p.yb = yb; p.now = now;
        return p;
    endfunction

    function automatic int clip(int v);
        return (v > 1023) ? 1023 : (v < -1024) ? -1024 : v;
    endfunction

    // Waits until every queued beat is sent and every command has come back, then a bit
    // longer in case a dropped beat is still passing through.
    task automatic drain();
        while (pose_q.size() != 0 || i_in_valid || steer_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [pshs_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[pshs_pkg::CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            pshs_pkg::CFG_MIN_SPEED:  nav.min_spd = val & 'h7F;
            pshs_pkg::CFG_MAX_SPEED:  nav.max_spd = val & 'h7F;
            pshs_pkg::CFG_PARK_DIST:  nav.park_dist = val & 'h7FF;
            default:                  nav.dwell = val & 'hFFFF;
        endcase
    endtask

    task automatic random_poses(input int count);
        int cx, cy, gx, gy, r, span;
        logic [pshs_pkg::TIME_W-1:0] now;
        now = $urandom;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 15) begin
                cx = $urandom_range(2047) - 1024; cy = $urandom_range(2047) - 1024;
                gx = $urandom_range(2047) - 1024; gy = $urandom_range(2047) - 1024;
            end else begin
                span = (r < 55) ? 40 : 400;
                cx = $urandom_range(2047) - 1024; cy = $urandom_range(2047) - 1024;
                gx = clip(cx + $urandom_range(2 * span) - span);
                gy = clip(cy + $urandom_range(2 * span) - span);
            end
            if ($urandom_range(9) == 0) now = $urandom;
            else now += $urandom_range(300);
            r = $urandom_range(99);
            queue_pose(make_pose(cx, cy, gx, gy, r >= 70 && r < 85 || r >= 95,
                                 r >= 85, now), 1'b0);
        end
    endtask

    // The input beat is taken at a rising edge; the driver acts on the following fall.
    always @(posedge i_clk) begin
        in_taken <= i_in_valid && o_in_ready;
        cycles <= cycles + 1;
    end

    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (pose_q.size() != 0 && (calm || $urandom_range(99) >= 14)) begin
                i_cur_x <= pose_q[0].cx;
                i_cur_y <= pose_q[0].cy;
                i_goal_x <= pose_q[0].gx;
                i_goal_y <= pose_q[0].gy;
                i_x_blocked <= pose_q[0].xb;
                i_y_blocked <= pose_q[0].yb;
                i_now_ms <= pose_q[0].now;
                void'(pose_q.pop_front());
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off that backs the block up.
    always @(negedge i_clk) begin
        if (cycles == 30000) hold_left = 3000;
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || $urandom_range(99) >= 14;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (steer_q.size() == 0) begin
                $error("command beat with no expectation: heading %0d speed %0d",
                       o_heading, o_speed_cmd);
                fails++;
            end else begin
                if (o_heading !== steer_q[0].head) begin
                    $error("heading: expected %0d, got %0d", steer_q[0].head, o_heading);
                    fails++;
                end
                if (o_speed_cmd !== steer_q[0].spd) begin
                    $error("speed_cmd: expected %0d, got %0d", steer_q[0].spd, o_speed_cmd);
                    fails++;
                end
                if (o_is_parked !== steer_q[0].parked) begin
                    $error("is_parked: expected %0d, got %0d", steer_q[0].parked, o_is_parked);
                    fails++;
                end
                void'(steer_q.pop_front());
            end
        end
    end

    initial begin
        int unsigned plan[5][4] = '{'{0, 100, 2047, 65535}, '{100, 0, 0, 0},
                                    '{50, 50, 300, 10}, '{7, 90, 120, 1000},
                                    '{100, 100, 1, 65535}};
        make_sines();
        nav = '{min_spd: pshs_pkg::RST_MIN_SPEED, max_spd: pshs_pkg::RST_MAX_SPEED,
                park_dist: pshs_pkg::RST_PARK_DIST, dwell: pshs_pkg::RST_PARK_DWELL,
                parked: 0, armed: 0, start: 0, lhead: 0, lspd: 0};
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: coordinate extremes, each blocked combination, zero vector, due axes.
        queue_pose(make_pose(-1024, -1024, 1023, 1023, 0, 0, 0), 1'b0);
        queue_pose(make_pose(1023, 1023, -1024, -1024, 0, 0, 'hFFFF_FFFF), 1'b0);
        queue_pose(make_pose(-1024, 1023, 1023, -1024, 0, 0, 5), 1'b0);
        queue_pose(make_pose(1023, -1024, -1024, 1023, 0, 0, 9), 1'b0);
        queue_pose(make_pose(0, 0, 0, 0, 0, 0, 10), 1'b0);
        queue_pose(make_pose(5, 5, 5, 900, 0, 0, 20), 1'b0);
        queue_pose(make_pose(5, 5, 5, -900, 0, 0, 30), 1'b0);
        queue_pose(make_pose(5, 5, 900, 5, 0, 0, 40), 1'b0);
        queue_pose(make_pose(5, 5, -900, 5, 0, 0, 50), 1'b0);
        queue_pose(make_pose(0, 0, -1, 1000, 0, 0, 60), 1'b0);
        queue_pose(make_pose(0, 0, 300, 100, 1, 0, 70), 1'b0);
        queue_pose(make_pose(0, 0, 300, -100, 1, 0, 80), 1'b0);
        queue_pose(make_pose(0, 0, 300, 0, 1, 0, 85), 1'b0);
        queue_pose(make_pose(0, 0, 100, 300, 0, 1, 90), 1'b0);
        queue_pose(make_pose(0, 0, -100, 300, 0, 1, 100), 1'b0);
        queue_pose(make_pose(-1024, 0, 1023, 0, 0, 1, 105), 1'b0);
        queue_pose(make_pose(7, 7, 500, 500, 1, 1, 110), 1'b0);
        queue_pose(make_pose(0, 0, 3, 4, 0, 0, 120), 1'b0);
        queue_pose(make_pose(0, 0, 3, 4, 0, 0, 200), 1'b0);
        queue_pose(make_pose(0, 0, 3, 4, 0, 0, 320), 1'b0);
        calm = 1'b1;
        random_poses(150);
        drain();
        calm = 1'b0;

        for (int ph = 0; ph < 5; ph++) begin
            for (int r = 0; r < 4; r++) cfg_write(r[pshs_pkg::CFG_IDX_W-1:0], plan[ph][r]);
            random_poses(210);
            drain();
        end

        // Parking last: once parked the block stays silent, so later beats are dropped.
        cfg_write(pshs_pkg::CFG_MIN_SPEED, 20);
        cfg_write(pshs_pkg::CFG_MAX_SPEED, 60);
        cfg_write(pshs_pkg::CFG_PARK_DIST, 100);
        cfg_write(pshs_pkg::CFG_PARK_DWELL, 10);
        queue_pose(make_pose(0, 0, 30, 40, 0, 0, 1000), 1'b1);
        queue_pose(make_pose(0, 0, 30, -40, 0, 0, 1005), 1'b1);
        queue_pose(make_pose(0, 0, -30, 40, 0, 0, 1011), 1'b1);
        for (int i = 0; i < 5; i++) begin
            queue_pose(make_pose(0, 0, 800, -800, i[0], i[1], 2000 + i), 1'b1);
        end
        drain();

        if (fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/pshs_pkg.sv
rtl/pshs_queue.sv
rtl/pshs_front.sv
rtl/pshs_back.sv
rtl/point_seek_heading_speed_top.sv
test/point_seek_heading_speed_top_tb.sv
